/* hw/rtl/assert_macros.svh */
// assertion macros for the rtl folder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on clk, off during rst
`define ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, clocked on clk, off during rst
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hw/rtl/dibs_pkg.sv */
// types, codes and constants of the dual image boot selector
package dibs_pkg;

  localparam int unsigned CntW   = 6;
  localparam int unsigned VerW   = 8;
  localparam int unsigned ScoreW = 8;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;

  localparam logic [1:0] REQ_REPORT = 2'd0;
  localparam logic [1:0] REQ_CLEAR  = 2'd1;
  localparam logic [1:0] REQ_SELECT = 2'd2;

  localparam logic [1:0] DEC_SLOT0    = 2'd0;
  localparam logic [1:0] DEC_SLOT1    = 2'd1;
  localparam logic [1:0] DEC_FALLBACK = 2'd2;

  localparam logic [2:0] REG_SLOT0_BASE = 3'd0;
  localparam logic [2:0] REG_SLOT_SIZE  = 3'd1;
  localparam logic [2:0] REG_COUNT_LIM  = 3'd2;
  localparam logic [2:0] REG_SAVED_VER  = 3'd3;
  localparam logic [2:0] REG_VER_MASK   = 3'd4;

  localparam logic [31:0] STACK_MASK  = 32'h2FFE_0000;
  localparam logic [31:0] STACK_MATCH = 32'h2000_0000;
  localparam logic [8:0]  PRESENT_SCORE = 9'd2;

  localparam logic [31:0]   RST_SLOT0_BASE = 32'd0;
  localparam logic [30:0]   RST_SLOT_SIZE  = 31'd262144;
  localparam logic [CntW-1:0] RST_COUNT_LIM = 6'd3;
  localparam logic [VerW-1:0] RST_SAVED_VER = 8'd0;
  localparam logic [VerW-1:0] RST_VER_MASK  = 8'hFF;

  typedef struct packed {
    logic [31:0]     slot0_base;
    logic [30:0]     slot_size;
    logic [CntW-1:0] count_limit;
    logic [VerW-1:0] saved_hw_version;
    logic [VerW-1:0] hw_version_mask;
  } cfg_t;

  typedef struct packed {
    logic [1:0]      req_type;
    logic            slot;
    logic            run_ok;
    logic [31:0]     stack_word0;
    logic [31:0]     entry_addr0;
    logic [VerW-1:0] image_hw_version0;
    logic [31:0]     stack_word1;
    logic [31:0]     entry_addr1;
    logic [VerW-1:0] image_hw_version1;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        decision;
    logic [ScoreW-1:0] score_a;
    logic [ScoreW-1:0] score_b;
    logic [CntW-1:0]   pass_count;
    logic [CntW-1:0]   fail_count;
  } out_item_t;

endpackage

/* hw/rtl/dibs_in_if.sv */
// request channel interface
interface dibs_in_if;
  import dibs_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/dibs_out_if.sv */
// result channel interface
interface dibs_out_if;
  import dibs_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/dibs_apb_regs.sv */
// apb configuration register file
module dibs_apb_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [dibs_pkg::AddrW-1:0] paddr,
  input  logic [dibs_pkg::DataW-1:0] pwdata,
  output logic [dibs_pkg::DataW-1:0] prdata,
  output logic                       pready,
  output dibs_pkg::cfg_t             cfg
);
  import dibs_pkg::*;

  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[AddrW-1:2];
  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slot0_base       <= RST_SLOT0_BASE;
      cfg.slot_size        <= RST_SLOT_SIZE;
      cfg.count_limit      <= RST_COUNT_LIM;
      cfg.saved_hw_version <= RST_SAVED_VER;
      cfg.hw_version_mask  <= RST_VER_MASK;
    end else if (wr_en) begin
      case (reg_idx)
        REG_SLOT0_BASE: cfg.slot0_base       <= pwdata;
        REG_SLOT_SIZE:  cfg.slot_size        <= pwdata[30:0];
        REG_COUNT_LIM:  cfg.count_limit      <= pwdata[CntW-1:0];
        REG_SAVED_VER:  cfg.saved_hw_version <= pwdata[VerW-1:0];
        REG_VER_MASK:   cfg.hw_version_mask  <= pwdata[VerW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SLOT0_BASE: prdata = cfg.slot0_base;
      REG_SLOT_SIZE:  prdata = {1'b0, cfg.slot_size};
      REG_COUNT_LIM:  prdata = {{(DataW-CntW){1'b0}}, cfg.count_limit};
      REG_SAVED_VER:  prdata = {{(DataW-VerW){1'b0}}, cfg.saved_hw_version};
      REG_VER_MASK:   prdata = {{(DataW-VerW){1'b0}}, cfg.hw_version_mask};
      default:        prdata = '0;
    endcase
  end
endmodule

/* hw/rtl/dibs_score.sv */
// score of one image slot
module dibs_score (
  input  logic [33:0]                 base,
  input  logic [33:0]                 top,
  input  logic [31:0]                 stack_word,
  input  logic [31:0]                 entry_addr,
  input  logic [dibs_pkg::VerW-1:0]   image_ver,
  input  logic [dibs_pkg::VerW-1:0]   saved_ver,
  input  logic [dibs_pkg::VerW-1:0]   ver_mask,
  input  logic [dibs_pkg::CntW-1:0]   pass_ctr,
  input  logic [dibs_pkg::CntW-1:0]   fail_ctr,
  input  logic [dibs_pkg::CntW-1:0]   count_limit,
  output logic [dibs_pkg::ScoreW-1:0] score
);
  import dibs_pkg::*;

  logic       present;
  logic       ver_match;
  logic [6:0] diff;
  logic [8:0] raw;

  assign present = ((stack_word & STACK_MASK) == STACK_MATCH)
                 && ({2'b00, entry_addr} >= base)
                 && ({2'b00, entry_addr} <= top);
  assign ver_match = (image_ver & ver_mask) == (saved_ver & ver_mask);
  assign diff = {1'b0, pass_ctr} - {1'b0, fail_ctr};
  // signed 2 + 2 * (pass - fail)
  assign raw = PRESENT_SCORE + {diff[6], diff, 1'b0};

  always_comb begin
    if (!present) begin
      score = '0;
    end else if (!ver_match) begin
      score = PRESENT_SCORE[ScoreW-1:0];
    end else if (fail_ctr == count_limit) begin
      score = '0;
    end else if (raw[8] || (raw == 9'd0)) begin
      score = 8'd1;
    end else begin
      score = raw[ScoreW-1:0];
    end
  end
endmodule

/* hw/rtl/dual_image_boot_selector_core.sv */
// top level of the dual image boot selector
// One request beat in, one result beat out, one request per cycle sustained
// while the result side is not stalled. A request is captured in an input
// register; from there the scoring, the counter update and the tie-break step
// run in one pass of logic and land in the result register once that register
// is empty or its beat is being taken, and the result beat is offered from the
// result register. The pass/fail counters and tie pointer change as a request
// moves into the result register, so back-to-back requests always see the
// effects of the ones before them. Configuration must be written by the user
// through the apb port while no request is in flight; the block does not check.
`include "assert_macros.svh"

module dual_image_boot_selector_core (
  input  logic                       clk,
  input  logic                       rst,
  dibs_in_if.sink                    req,
  dibs_out_if.source                 rsp,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [dibs_pkg::AddrW-1:0] paddr,
  input  logic [dibs_pkg::DataW-1:0] pwdata,
  output logic [dibs_pkg::DataW-1:0] prdata,
  output logic                       pready
);
  import dibs_pkg::*;

  cfg_t            cfg;
  logic            s1_valid;
  in_item_t        s1;
  logic            out_valid;
  out_item_t       out_data;
  out_item_t       out_next;
  logic            advance;
  logic [CntW-1:0] pass_ctr [2];
  logic [CntW-1:0] fail_ctr [2];
  logic [CntW-1:0] pass_ctr_next [2];
  logic [CntW-1:0] fail_ctr_next [2];
  logic            tie_ptr;
  logic            tie_ptr_next;
  logic [33:0]     base0;
  logic [33:0]     top0;
  logic [33:0]     top1;
  logic [ScoreW-1:0] sa;
  logic [ScoreW-1:0] sb;
  logic            is_report;
  logic            is_clear;
  logic            is_select;

  dibs_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign base0 = {2'b00, cfg.slot0_base};
  assign top0  = base0 + {3'b000, cfg.slot_size};
  assign top1  = top0 + {3'b000, cfg.slot_size};

  dibs_score u_score0 (
    .base        (base0),
    .top         (top0),
    .stack_word  (s1.stack_word0),
    .entry_addr  (s1.entry_addr0),
    .image_ver   (s1.image_hw_version0),
    .saved_ver   (cfg.saved_hw_version),
    .ver_mask    (cfg.hw_version_mask),
    .pass_ctr    (pass_ctr[0]),
    .fail_ctr    (fail_ctr[0]),
    .count_limit (cfg.count_limit),
    .score       (sa)
  );

  dibs_score u_score1 (
    .base        (top0),
    .top         (top1),
    .stack_word  (s1.stack_word1),
    .entry_addr  (s1.entry_addr1),
    .image_ver   (s1.image_hw_version1),
    .saved_ver   (cfg.saved_hw_version),
    .ver_mask    (cfg.hw_version_mask),
    .pass_ctr    (pass_ctr[1]),
    .fail_ctr    (fail_ctr[1]),
    .count_limit (cfg.count_limit),
    .score       (sb)
  );

  // handshake and pipeline control
  assign advance   = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !s1_valid || advance;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  assign is_report = s1.req_type == REQ_REPORT;
  assign is_clear  = s1.req_type == REQ_CLEAR;
  assign is_select = s1.req_type == REQ_SELECT;

  // counter update
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      pass_ctr_next[i] = pass_ctr[i];
      fail_ctr_next[i] = fail_ctr[i];
      if (is_clear) begin
        pass_ctr_next[i] = '0;
        fail_ctr_next[i] = '0;
      end else if (is_report && (s1.slot == i[0])) begin
        if (s1.run_ok) begin
          if (pass_ctr[i] < cfg.count_limit) pass_ctr_next[i] = pass_ctr[i] + 1'b1;
          if (fail_ctr[i] != '0) fail_ctr_next[i] = fail_ctr[i] - 1'b1;
        end else begin
          if (pass_ctr[i] != '0) pass_ctr_next[i] = pass_ctr[i] - 1'b1;
          if (fail_ctr[i] < cfg.count_limit) fail_ctr_next[i] = fail_ctr[i] + 1'b1;
        end
      end
    end
  end

  // decision and result beat
  always_comb begin
    tie_ptr_next        = tie_ptr;
    out_next.decision   = DEC_SLOT0;
    out_next.score_a    = '0;
    out_next.score_b    = '0;
    out_next.pass_count = pass_ctr_next[s1.slot];
    out_next.fail_count = fail_ctr_next[s1.slot];
    if (is_select) begin
      out_next.score_a = sa;
      out_next.score_b = sb;
      if (sa > sb) begin
        out_next.decision = DEC_SLOT0;
      end else if (sa < sb) begin
        out_next.decision = DEC_SLOT1;
      end else if (sa == '0) begin
        out_next.decision = DEC_FALLBACK;
      end else begin
        out_next.decision = tie_ptr ? DEC_SLOT1 : DEC_SLOT0;
        tie_ptr_next      = ~tie_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      out_valid   <= 1'b0;
      tie_ptr     <= 1'b0;
      pass_ctr[0] <= '0;
      pass_ctr[1] <= '0;
      fail_ctr[0] <= '0;
      fail_ctr[1] <= '0;
    end else begin
      if (req.valid && req.ready) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        out_valid   <= 1'b1;
        tie_ptr     <= tie_ptr_next;
        pass_ctr[0] <= pass_ctr_next[0];
        pass_ctr[1] <= pass_ctr_next[1];
        fail_ctr[0] <= fail_ctr_next[0];
        fail_ctr[1] <= fail_ctr_next[1];
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1 <= req.data;
    end
    if (advance) begin
      out_data <= out_next;
    end
  end

  `ASSERT_NOW(a_fallback_zero, out_valid && (out_data.decision == DEC_FALLBACK), (out_data.score_a == '0) && (out_data.score_b == '0))
  `ASSERT_NEXT(a_clear_zero, advance && is_clear, (pass_ctr[0] == '0) && (pass_ctr[1] == '0) && (fail_ctr[0] == '0) && (fail_ctr[1] == '0))
  `ASSERT_NEXT(a_tie_hold, !(advance && is_select), tie_ptr == $past(tie_ptr))
  `ASSERT_NEXT(a_stage_kept, s1_valid && !advance, s1_valid)
endmodule
